// ===== rtl/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types, widths, register codes and helper functions for the affine
// point transform: Q16.16 coordinates, wide partial sums, coefficient lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

   // Q16.16 fixed point
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   // full product of two Q16.16 words
   localparam int PROD_W  = 2 * COORD_W;
   // three products plus the shifted translation, with headroom
   localparam int ACC_W   = PROD_W + 2;
   // sum after dropping the fraction bits
   localparam int SHR_W   = ACC_W - FRAC_W;

   // one cell per input coordinate, one lane per output row
   localparam int NUM_CELLS = 3;
   localparam int NUM_ROWS  = 3;

   // configuration file
   localparam int NUM_REGS  = 6;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ROW0_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_SECOND = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_SECOND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_FIRST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_SECOND = 3'd5;

   localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   typedef coord_type [NUM_ROWS-1:0]  coord_vec_type;
   typedef prod_type  [NUM_ROWS-1:0]  prod_vec_type;
   typedef acc_type   [NUM_ROWS-1:0]  acc_vec_type;

   typedef logic [CSR_W-1:0]          csr_word_type;
   typedef csr_word_type [NUM_REGS-1:0] csr_file_type;

   // Coefficient of one row and one column (column 3 is the translation).
   function automatic coord_type col_coeff(csr_file_type csr, int row, int col);
      csr_word_type first;
      csr_word_type second;
      first  = csr[2*row];
      second = csr[2*row+1];
      case (col)
         0:       col_coeff = first[COORD_W-1:0];
         1:       col_coeff = first[CSR_W-1:COORD_W];
         2:       col_coeff = second[COORD_W-1:0];
         default: col_coeff = second[CSR_W-1:COORD_W];
      endcase
   endfunction

   // Translation times 1.0, i.e. sign extended and shifted up by the fraction.
   function automatic acc_type init_psum(coord_type t);
      init_psum = {{(ACC_W-COORD_W-FRAC_W){t[COORD_W-1]}}, t, {FRAC_W{1'b0}}};
   endfunction

   // Sign extend a full product to the accumulator width.
   function automatic acc_type ext_prod(prod_type p);
      ext_prod = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   // Floor shift by the fraction width, then saturate to a coordinate.
   function automatic coord_type shift_sat(acc_type a);
      logic [SHR_W-1:0] sh;
      sh = a[ACC_W-1:FRAC_W];
      if ((&sh[SHR_W-1:COORD_W-1]) || !(|sh[SHR_W-1:COORD_W-1])) begin
         shift_sat = sh[COORD_W-1:0];
      end else if (sh[SHR_W-1]) begin
         shift_sat = SAT_MIN;
      end else begin
         shift_sat = SAT_MAX;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/apt_cell.sv =====
// ----------------------------------------------------------------------------
// apt_cell
// One multiply-accumulate cell of the chain. It takes the leading coordinate
// of the item, multiplies it by its column's coefficient for each row, adds
// the products to the partial sums handed in, and passes the remaining
// coordinates on. Two register stages: products, then sums.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  apt_pkg::coord_vec_type coeff_col,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  apt_pkg::coord_vec_type in_coords,
   input  apt_pkg::acc_vec_type   in_psum,
   output logic                   out_valid,
   input  logic                   out_ready,
   output apt_pkg::coord_vec_type out_coords,
   output apt_pkg::acc_vec_type   out_psum
);

   logic                   va_ff, va_in;
   logic                   vb_ff, vb_in;
   logic                   ready_a;
   logic                   ready_b;
   apt_pkg::prod_vec_type  prod_a_ff, prod_a_in;
   apt_pkg::coord_vec_type coords_a_ff, coords_a_in;
   apt_pkg::acc_vec_type   psum_a_ff;
   apt_pkg::coord_vec_type coords_b_ff;
   apt_pkg::acc_vec_type   psum_b_ff, psum_b_in;

   // stage readiness, a stage moves when empty or when its successor moves
   assign ready_b  = !vb_ff || out_ready;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   assign va_in = ready_a ? in_valid : va_ff;
   assign vb_in = ready_b ? va_ff : vb_ff;

   // products of the leading coordinate, remaining coordinates move down
   always_comb begin
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         prod_a_in[r] = $signed(coeff_col[r]) * $signed(in_coords[0]);
      end
      coords_a_in = in_coords >> apt_pkg::COORD_W;
   end

   // accumulate
   always_comb begin
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         psum_b_in[r] = psum_a_ff[r] + apt_pkg::ext_prod(prod_a_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         prod_a_ff   <= prod_a_in;
         coords_a_ff <= coords_a_in;
         psum_a_ff   <= in_psum;
      end
      if (ready_b) begin
         coords_b_ff <= coords_a_ff;
         psum_b_ff   <= psum_b_in;
      end
   end

   assign out_valid  = vb_ff;
   assign out_coords = coords_b_ff;
   assign out_psum   = psum_b_ff;

endmodule

`default_nettype wire

// ===== rtl/apt_out_stage.sv =====
// ----------------------------------------------------------------------------
// apt_out_stage
// Result register. Drops the fraction bits of each row sum (floor), clamps to
// the Q16.16 range and holds the item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  apt_pkg::acc_vec_type   in_psum,
   output logic                   out_valid,
   input  logic                   out_stall,
   output apt_pkg::coord_vec_type out_data
);

   logic                   valid_ff, valid_in;
   apt_pkg::coord_vec_type data_ff, data_in;

   // take a new item when empty or when the held one leaves this cycle
   assign in_ready = !valid_ff || !out_stall;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         data_in[r] = apt_pkg::shift_sat(in_psum[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/affine_point_transform_core.sv =====
// ----------------------------------------------------------------------------
// affine_point_transform_core
// Transforms a Q16.16 point (x, y, z, 1) by the upper three rows of a 4x4
// matrix held in six 64-bit configuration registers; saturated Q16.16 result.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one point per item, accepted when req_valid is high and
//            req_stall is low.
//   rsp_*  : one transformed point per item, taken when rsp_valid is high
//            and rsp_stall is low; items leave in the order they came in.
//   csr_*  : matrix writes, one 64-bit register per cycle while no item is
//            in flight; indexes beyond the register file are ignored.
//   An accepted item passes three multiply-add cells of two stages each
//   (one cell per coordinate, all three rows in parallel lanes) and the
//   result register. Throughput is one item per cycle without stalls,
//   set by the cell chain, one 32x32 multiplier per lane per cell.
//   When the receiver stalls, the held result stays put and the chain keeps
//   filling its empty stages; req_stall rises only once every stage is full.
//   Reset empties the chain and clears all matrix registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_point_transform_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [apt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [apt_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [apt_pkg::COORD_W-1:0]  req_in_x,
   input  logic signed [apt_pkg::COORD_W-1:0]  req_in_y,
   input  logic signed [apt_pkg::COORD_W-1:0]  req_in_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [apt_pkg::COORD_W-1:0]  rsp_out_x,
   output logic signed [apt_pkg::COORD_W-1:0]  rsp_out_y,
   output logic signed [apt_pkg::COORD_W-1:0]  rsp_out_z
);

   localparam int NC = apt_pkg::NUM_CELLS;

   apt_pkg::csr_file_type  csr_ff, csr_in;
   logic [NC:0]            link_valid;
   logic [NC:0]            link_ready;
   apt_pkg::coord_vec_type link_coords [NC+1];
   apt_pkg::acc_vec_type   link_psum   [NC+1];
   apt_pkg::coord_vec_type cell_coeff  [NC];
   apt_pkg::coord_vec_type out_data;

   // matrix register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index) inside
            apt_pkg::REG_ROW0_FIRST, apt_pkg::REG_ROW0_SECOND,
            apt_pkg::REG_ROW1_FIRST, apt_pkg::REG_ROW1_SECOND,
            apt_pkg::REG_ROW2_FIRST, apt_pkg::REG_ROW2_SECOND: begin
               csr_in[csr_index] = csr_wdata;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // chain head: coordinates in, partial sums start at the translation
   assign link_valid[0]  = req_valid;
   assign req_stall      = !link_ready[0];
   assign link_coords[0] = {req_in_z, req_in_y, req_in_x};

   always_comb begin
      for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
         link_psum[0][r] = apt_pkg::init_psum(apt_pkg::col_coeff(csr_ff, r, NC));
      end
   end

   // one cell per coordinate column
   for (genvar k = 0; k < NC; k++) begin : g_chain
      always_comb begin
         for (int r = 0; r < apt_pkg::NUM_ROWS; r++) begin
            cell_coeff[k][r] = apt_pkg::col_coeff(csr_ff, r, k);
         end
      end

      apt_cell u_mac (
         .clock      (clock),
         .reset      (reset),
         .coeff_col  (cell_coeff[k]),
         .in_valid   (link_valid[k]),
         .in_ready   (link_ready[k]),
         .in_coords  (link_coords[k]),
         .in_psum    (link_psum[k]),
         .out_valid  (link_valid[k+1]),
         .out_ready  (link_ready[k+1]),
         .out_coords (link_coords[k+1]),
         .out_psum   (link_psum[k+1])
      );
   end

   // result register
   apt_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[NC]),
      .in_ready  (link_ready[NC]),
      .in_psum   (link_psum[NC]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_out_x = out_data[0];
   assign rsp_out_y = out_data[1];
   assign rsp_out_z = out_data[2];

endmodule

`default_nettype wire

// ===== rtl/apt_checker.sv =====
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks for the affine point transform: reset behavior, result
// hold under stall, flow-through when the receiver is ready, and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module apt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [apt_pkg::COORD_W-1:0]  rsp_out_x,
   input logic signed [apt_pkg::COORD_W-1:0]  rsp_out_y,
   input logic signed [apt_pkg::COORD_W-1:0]  rsp_out_z
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z)))
      else $error("stalled result changed");

   // a free-running receiver never backs up the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while receiver ready");

   // accepted item reaches rsp_valid when nothing stalls
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind affine_point_transform_core apt_checker u_apt_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for affine_point_transform_core. Loads a series of
// matrices through the register port and streams Q16.16 points through the
// core with random idle gaps on both sides. Each result is checked field by
// field against a bit-exact transform computed in the bench.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // wide enough for three full products plus the shifted translation
   typedef logic signed [79:0] wide_type;

   typedef struct packed {
      apt_pkg::coord_type x;
      apt_pkg::coord_type y;
      apt_pkg::coord_type z;
   } point_type;

   typedef enum {MAT_MODERATE, MAT_FULL, MAT_EXTREME} matrix_kind_type;

   localparam int FRAC_BITS = 16;
   localparam int LATENCY_CYCLES = 7;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 210;

   // indexes past the register file; writes there must be dropped
   localparam logic [apt_pkg::CSR_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [apt_pkg::CSR_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

   localparam wide_type POS_LIMIT = wide_type'(32'sh7FFF_FFFF);
   localparam wide_type NEG_LIMIT = wide_type'(32'sh8000_0000);

   localparam apt_pkg::coord_type Q_ONE  = 32'h0001_0000;
   localparam apt_pkg::coord_type Q_HALF = 32'h0000_8000;
   localparam apt_pkg::coord_type Q_MAX  = 32'h7FFF_FFFF;
   localparam apt_pkg::coord_type Q_MIN  = 32'h8000_0000;

   // Matrix copy, expected transformed points and the comparison.
   class transform_scoreboard;
      apt_pkg::csr_word_type matrix [apt_pkg::NUM_REGS];
      point_type expected_points[$];
      int n_errors;
      int n_checked;

      function new();
         foreach (matrix[i]) matrix[i] = '0;
         n_errors = 0;
         n_checked = 0;
      endfunction

      function void write_reg(logic [apt_pkg::CSR_IDX_W-1:0] idx,
                              apt_pkg::csr_word_type data);
         if (idx < apt_pkg::NUM_REGS) matrix[idx] = data;
      endfunction

      // one output row: exact sum, floor shift, saturate
      function apt_pkg::coord_type transform_row(int row, apt_pkg::coord_type x,
                                                 apt_pkg::coord_type y,
                                                 apt_pkg::coord_type z);
         apt_pkg::csr_word_type first;
         apt_pkg::csr_word_type second;
         apt_pkg::coord_type c0, c1, c2, t;
         wide_type sum;
         wide_type floored;
         first  = matrix[2*row];
         second = matrix[2*row+1];
         c0 = first[31:0];
         c1 = first[63:32];
         c2 = second[31:0];
         t  = second[63:32];
         sum = wide_type'(c0) * wide_type'(x) + wide_type'(c1) * wide_type'(y)
             + wide_type'(c2) * wide_type'(z) + (wide_type'(t) <<< FRAC_BITS);
         floored = sum >>> FRAC_BITS;
         if (floored > POS_LIMIT) return Q_MAX;
         if (floored < NEG_LIMIT) return Q_MIN;
         return floored[31:0];
      endfunction

      function void note_point(apt_pkg::coord_type x, apt_pkg::coord_type y,
                               apt_pkg::coord_type z);
         point_type p;
         p.x = transform_row(0, x, y, z);
         p.y = transform_row(1, x, y, z);
         p.z = transform_row(2, x, y, z);
         expected_points.push_back(p);
      endfunction

      function void check_point(apt_pkg::coord_type x, apt_pkg::coord_type y,
                                apt_pkg::coord_type z);
         point_type want;
         if (expected_points.size() == 0) begin
            $error("unexpected transformed point %h %h %h", x, y, z);
            n_errors++;
            return;
         end
         want = expected_points.pop_front();
         n_checked++;
         if (x !== want.x) begin
            $error("out_x: expected %h, actual %h", want.x, x);
            n_errors++;
         end
         if (y !== want.y) begin
            $error("out_y: expected %h, actual %h", want.y, y);
            n_errors++;
         end
         if (z !== want.z) begin
            $error("out_z: expected %h, actual %h", want.z, z);
            n_errors++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [apt_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [apt_pkg::CSR_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   apt_pkg::coord_type req_in_x = '0;
   apt_pkg::coord_type req_in_y = '0;
   apt_pkg::coord_type req_in_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   apt_pkg::coord_type rsp_out_x;
   apt_pkg::coord_type rsp_out_y;
   apt_pkg::coord_type rsp_out_z;

   transform_scoreboard transforms;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;
   bit long_hold_request = 1'b0;
   int n_sent = 0;
   int n_settings = 0;

   affine_point_transform_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_x         (req_in_x),
      .req_in_y         (req_in_y),
      .req_in_z         (req_in_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic apt_pkg::coord_type rand_scaled(int bits);
      return $signed($urandom) >>> (32 - bits);
   endfunction

   function automatic apt_pkg::coord_type extreme_word();
      case ($urandom_range(0, 5))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         4: return Q_ONE;
         default: return 32'h1;
      endcase
   endfunction

   function automatic apt_pkg::coord_type rand_coord();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return rand_scaled($urandom_range(18, 24));
      if (r < 70) return $urandom;
      if (r < 85) return extreme_word();
      return rand_scaled($urandom_range(1, 17));
   endfunction

   function automatic apt_pkg::csr_file_type rand_matrix(matrix_kind_type kind);
      apt_pkg::csr_file_type m;
      for (int i = 0; i < apt_pkg::NUM_REGS; i++) begin
         case (kind)
            MAT_MODERATE: m[i] = {rand_scaled(22), rand_scaled(19)};
            MAT_FULL:     m[i] = {$urandom, $urandom};
            default:      m[i] = {extreme_word(), extreme_word()};
         endcase
      end
      return m;
   endfunction

   // one register write; the write lands at the next edge
   task automatic write_reg(logic [apt_pkg::CSR_IDX_W-1:0] idx,
                            apt_pkg::csr_word_type data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      transforms.write_reg(idx, data);
   endtask

   task automatic load_matrix(apt_pkg::csr_file_type m);
      write_reg(apt_pkg::REG_ROW0_FIRST,  m[0]);
      write_reg(apt_pkg::REG_ROW0_SECOND, m[1]);
      write_reg(apt_pkg::REG_ROW1_FIRST,  m[2]);
      write_reg(apt_pkg::REG_ROW1_SECOND, m[3]);
      write_reg(apt_pkg::REG_ROW2_FIRST,  m[4]);
      write_reg(apt_pkg::REG_ROW2_SECOND, m[5]);
      if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7,
                                          {$urandom, $urandom});
      csr_write_enable <= 1'b0;
      n_settings++;
   endtask

   // offer one item and hold it until accepted
   task automatic send_point(apt_pkg::coord_type x, apt_pkg::coord_type y,
                             apt_pkg::coord_type z);
      int gap;
      req_valid <= 1'b1;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      do @(posedge clock); while (req_stall);
      transforms.note_point(x, y, z);
      n_sent++;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain_points();
      req_valid <= 1'b0;
      while (transforms.pending() != 0) @(posedge clock);
   endtask

   // receiver: checks results and stalls at random
   initial begin : receiver
      int stall_left;
      int open_left;
      stall_left = 0;
      open_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) transforms.check_point(rsp_out_x, rsp_out_y, rsp_out_z);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
            open_left = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (receiver_steady) begin
            rsp_stall <= 1'b0;
         end else if (open_left > 0) begin
            rsp_stall <= 1'b0;
            open_left--;
         end else begin
            stall_left = pick_gap();
            open_left = $urandom_range(1, 12);
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      apt_pkg::csr_file_type mat;
      matrix_kind_type kind;
      transforms = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset matrix is all zero: every result is zero
      send_point(Q_MAX, Q_MIN, 32'h0);
      send_point(32'hFFFF_FFFF, 32'h1, Q_MAX);
      drain_points();

      // identity with translation (1.5, -2.25, 0); saturates at the edges
      mat = '0;
      mat[0] = {32'h0, Q_ONE};
      mat[1] = {32'h0001_8000, 32'h0};
      mat[2] = {Q_ONE, 32'h0};
      mat[3] = {32'hFFFD_C000, 32'h0};
      mat[5] = {32'h0, Q_ONE};
      load_matrix(mat);
      send_point(32'h0, 32'h0, 32'h0);
      send_point(Q_MAX, Q_MIN, 32'h1);
      send_point(Q_MIN, Q_MAX, 32'hFFFF_FFFF);
      send_point(Q_ONE, 32'hFFFF_0000, Q_HALF);
      drain_points();

      // all entries at the positive extreme
      for (int i = 0; i < apt_pkg::NUM_REGS; i++) mat[i] = {Q_MAX, Q_MAX};
      load_matrix(mat);
      send_point(Q_MAX, Q_MAX, Q_MAX);
      send_point(Q_MIN, Q_MIN, Q_MIN);
      send_point(32'h1, 32'h1, 32'h1);
      drain_points();

      // all entries at the negative extreme
      for (int i = 0; i < apt_pkg::NUM_REGS; i++) mat[i] = {Q_MIN, Q_MIN};
      load_matrix(mat);
      send_point(Q_MIN, Q_MIN, Q_MIN);
      send_point(Q_MAX, Q_MAX, Q_MAX);
      drain_points();

      // half scale: negative sums must floor toward minus infinity
      mat = '0;
      mat[0] = {32'h0, Q_HALF};
      mat[2] = {Q_HALF, 32'h0};
      mat[5] = {32'h0, Q_HALF};
      load_matrix(mat);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h1);
      send_point(32'hFFFF_0001, 32'h3, 32'hFFFF_FFFE);
      drain_points();

      // writes past the register file leave the matrix untouched
      write_reg(REG_UNUSED_6, '1);
      write_reg(REG_UNUSED_7, '1);
      csr_write_enable <= 1'b0;
      send_point(32'hFFFF_FFFF, Q_ONE, 32'hFFFF_8000);
      send_point(Q_MIN, Q_MAX, 32'h0);
      drain_points();

      // random phases, one matrix setting each
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase % 4 == 3) begin
            kind = MAT_EXTREME;
         end else if (phase % 4 == 1) begin
            kind = MAT_FULL;
         end else begin
            kind = MAT_MODERATE;
         end
         load_matrix(rand_matrix(kind));
         receiver_steady = (phase == 5);
         sender_steady = (phase == 5);
         if (phase == 1) begin
            // receiver holds off while the sender keeps the core full
            long_hold_request = 1'b1;
            sender_steady = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 60) sender_steady = 1'b0;
            if (phase == 3 && n == ITEMS_PER_PHASE / 2) drain_points();
            send_point(rand_coord(), rand_coord(), rand_coord());
         end
         drain_points();
         sender_steady = 1'b0;
         receiver_steady = 1'b0;
      end

      repeat (LATENCY_CYCLES * 3) @(posedge clock);
      $display("Sent %0d points over %0d matrix settings, checked %0d results.",
               n_sent, n_settings, transforms.n_checked);
      if (transforms.n_errors == 0 && transforms.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("Mismatches: %0d, results still outstanding: %0d",
                  transforms.n_errors, transforms.pending());
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== affine_point_transform_core.f =====
rtl/apt_pkg.sv
rtl/apt_cell.sv
rtl/apt_out_stage.sv
rtl/affine_point_transform_core.sv
rtl/apt_checker.sv
tb/tb.sv
